[rtl/core/motor_ramp_stall_guard_assert.svh]
// Assertion macros for the motor ramp and stall guard block.
// Included by motor_ramp_stall_guard, which checks its own logic; no dependencies.
`ifndef MOTOR_RAMP_STALL_GUARD_ASSERT_SVH
`define MOTOR_RAMP_STALL_GUARD_ASSERT_SVH

// Check post in the same cycle whenever pre holds, outside reset.
`define MRSG_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check post in the cycle after pre holds, outside reset.
`define MRSG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/mrsg_pkg.sv]
// Shared types, constants and helpers for the motor ramp and stall guard.
// No dependencies; imported by mrsg_step, motor_ramp_stall_guard and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package mrsg_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RAMP_STEP    = 3'd0,
    CFG_CHECK_PERIOD = 3'd1,
    CFG_SETTLE       = 3'd2,
    CFG_PIN_HOLD     = 3'd3,
    CFG_STALL_LIMIT  = 3'd4
  } cfg_index_e;

  localparam logic [7:0]  RAMP_STEP_RESET    = 8'd10;
  localparam logic [7:0]  CHECK_PERIOD_RESET = 8'd20;
  localparam logic [15:0] SETTLE_RESET       = 16'd1000;
  localparam logic [15:0] PIN_HOLD_RESET     = 16'd5000;
  localparam logic [3:0]  STALL_LIMIT_RESET  = 4'd5;

  localparam logic [3:0] SLOW_MAX = 4'hF;

  typedef struct packed {
    logic [7:0]  ramp_step_ms;
    logic [7:0]  check_period_ms;
    logic [15:0] settle_ms;
    logic [15:0] pin_hold_ms;
    logic [3:0]  stall_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         target_speed;
    logic               direction_right;
    logic signed [31:0] encoder_count;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_in1;
    logic [7:0] drive_in2;
    logic [7:0] current_level;
    logic       pinned;
  } out_item_t;

  // Control state that does not depend on the time width
  typedef struct packed {
    logic [7:0]  level;
    logic        applied_direction;
    logic        reversal_pending;
    logic        wanted_direction;
    logic        ramping;
    logic [31:0] previous_count;
    logic [3:0]  slow_checks;
    logic        hold_active;
    logic [7:0]  pwm_one;
    logic [7:0]  pwm_two;
  } ctrl_t;

  // Speed percentage bands, compared as level*100 against pct*255
  localparam int PCT_SCALE = 255;
  localparam logic [14:0] BAND_32  = 15'(32 * PCT_SCALE);
  localparam logic [14:0] BAND_45  = 15'(45 * PCT_SCALE);
  localparam logic [14:0] BAND_50  = 15'(50 * PCT_SCALE);
  localparam logic [14:0] BAND_70  = 15'(70 * PCT_SCALE);
  localparam logic [14:0] BAND_90  = 15'(90 * PCT_SCALE);
  localparam logic [14:0] BAND_100 = 15'(100 * PCT_SCALE);

  // Minimum encoder movement per check for a given PWM level
  function automatic logic [7:0] stall_threshold(input logic [7:0] lv);
    logic [14:0] lv100;
    lv100 = 15'(lv) * 15'd100;
    if (lv100 < BAND_32) begin
      return 8'd20;
    end else if (lv100 < BAND_45) begin
      return 8'd40;
    end else if (lv100 < BAND_50) begin
      return 8'd45;
    end else if (lv100 < BAND_70) begin
      return 8'd80;
    end else if (lv100 < BAND_90) begin
      return 8'd90;
    end else if (lv100 < BAND_100) begin
      return 8'd140;
    end else begin
      return 8'd0;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/motor_ramp_stall_guard.sv]
// Motor ramp and stall guard, top level: handshake, configuration and state.
// Depends on mrsg_pkg, mrsg_step and motor_ramp_stall_guard_assert.svh.
//
// Each input word (commanded speed, direction, encoder count, millisecond
// time) yields exactly one result word: the two H-bridge PWM levels, the
// present ramped level and the stall-hold flag. The block takes one word per
// clock while the result slot is free or being read. A result is valid once
// its word has passed from the input register through one combinational
// update pass into the result register; a stalled output holds the word back.
// That single update pass, reading and writing all ramp and stall state, sets
// the rate of one word per cycle when unstalled. The level moves by one count
// at most once per ramp_step_ms, and a direction reversal first ramps the
// level to zero. Every check_period_ms, once the ramp has been still for
// settle_ms, encoder movement below a speed-banded threshold counts as a slow
// check; more than stall_limit slow checks in a row pin the speed to zero for
// pin_hold_ms. Time is compared modulo 2^TIME_BITS. Write configuration with
// cfg_write/cfg_index/cfg_data only while no word is in flight; writes to
// indexes past the register list are ignored.
`timescale 1ns / 1ps
`default_nettype none

`include "motor_ramp_stall_guard_assert.svh"

module motor_ramp_stall_guard
  import mrsg_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  cfg_t cfg;

  // Input register
  logic     s1_valid;
  in_item_t s1_data;

  // Ramp and stall state
  ctrl_t                st_q;
  logic [TIME_BITS-1:0] last_step_time;
  logic [TIME_BITS-1:0] last_check_time;
  logic [TIME_BITS-1:0] ramp_end_time;
  logic [TIME_BITS-1:0] hold_end_time;

  ctrl_t                st_next;
  logic [TIME_BITS-1:0] last_step_time_next;
  logic [TIME_BITS-1:0] last_check_time_next;
  logic [TIME_BITS-1:0] ramp_end_time_next;
  logic [TIME_BITS-1:0] hold_end_time_next;
  out_item_t            result;

  logic advance;

  // Advance the held word into the result register when that slot is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step_ms    <= RAMP_STEP_RESET;
      cfg.check_period_ms <= CHECK_PERIOD_RESET;
      cfg.settle_ms       <= SETTLE_RESET;
      cfg.pin_hold_ms     <= PIN_HOLD_RESET;
      cfg.stall_limit     <= STALL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RAMP_STEP:    cfg.ramp_step_ms    <= cfg_data[7:0];
        CFG_CHECK_PERIOD: cfg.check_period_ms <= cfg_data[7:0];
        CFG_SETTLE:       cfg.settle_ms       <= cfg_data;
        CFG_PIN_HOLD:     cfg.pin_hold_ms     <= cfg_data;
        CFG_STALL_LIMIT:  cfg.stall_limit     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register: take a word whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  mrsg_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item                 (s1_data),
    .cfg                  (cfg),
    .st                   (st_q),
    .last_step_time       (last_step_time),
    .last_check_time      (last_check_time),
    .ramp_end_time        (ramp_end_time),
    .hold_end_time        (hold_end_time),
    .st_next              (st_next),
    .last_step_time_next  (last_step_time_next),
    .last_check_time_next (last_check_time_next),
    .ramp_end_time_next   (ramp_end_time_next),
    .hold_end_time_next   (hold_end_time_next),
    .result               (result)
  );

  // Commit state only as a word advances, so a stalled output freezes it
  always_ff @(posedge clk) begin
    if (rst) begin
      st_q.level             <= 8'd0;
      st_q.applied_direction <= 1'b1;
      st_q.reversal_pending  <= 1'b0;
      st_q.wanted_direction  <= 1'b1;
      st_q.ramping           <= 1'b0;
      st_q.previous_count    <= 32'd0;
      st_q.slow_checks       <= 4'd0;
      st_q.hold_active       <= 1'b0;
      st_q.pwm_one           <= 8'd0;
      st_q.pwm_two           <= 8'd0;
      last_step_time         <= '0;
      last_check_time        <= '0;
      ramp_end_time          <= '0;
      hold_end_time          <= '0;
    end else if (advance) begin
      st_q            <= st_next;
      last_step_time  <= last_step_time_next;
      last_check_time <= last_check_time_next;
      ramp_end_time   <= ramp_end_time_next;
      hold_end_time   <= hold_end_time_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // The level moves by at most one count per word
  `MRSG_ASSERT_NEXT(a_level_single_step, clk, rst, advance,
    (st_q.level == $past(st_q.level)) ||
    (st_q.level == 8'($past(st_q.level) + 8'd1)) ||
    (st_q.level == 8'($past(st_q.level) - 8'd1)),
    "level moved by more than one count")

  // Only one bridge input carries the level; the other is zero
  `MRSG_ASSERT_IMPL(a_drive_matches_level, clk, rst, out_valid,
    (out_data.drive_in1 | out_data.drive_in2) == out_data.current_level,
    "bridge drive does not match the ramped level")

  // Slow checks never accumulate while ramping
  `MRSG_ASSERT_IMPL(a_no_slow_while_ramping, clk, rst, st_q.ramping,
    st_q.slow_checks == 4'd0,
    "slow checks counted during a ramp")

endmodule

`default_nettype wire

[rtl/core/mrsg_step.sv]
// Next-state and result logic for one word of the motor ramp and stall guard.
// Depends on mrsg_pkg; purely combinational, registered by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrsg_step
  import mrsg_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  in_item_t             item,
  input  cfg_t                 cfg,
  input  ctrl_t                st,
  input  logic [TIME_BITS-1:0] last_step_time,
  input  logic [TIME_BITS-1:0] last_check_time,
  input  logic [TIME_BITS-1:0] ramp_end_time,
  input  logic [TIME_BITS-1:0] hold_end_time,
  output ctrl_t                st_next,
  output logic [TIME_BITS-1:0] last_step_time_next,
  output logic [TIME_BITS-1:0] last_check_time_next,
  output logic [TIME_BITS-1:0] ramp_end_time_next,
  output logic [TIME_BITS-1:0] hold_end_time_next,
  output out_item_t            result
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] step_elapsed;
  logic [TIME_BITS-1:0] check_elapsed;
  logic [TIME_BITS-1:0] settle_elapsed;
  logic [TIME_BITS-1:0] hold_past;
  logic [7:0]           goal;
  logic                 right;
  logic [31:0]          diff;
  logic [31:0]          delta;
  logic [7:0]           need;

  always_comb begin
    now_t                = TIME_BITS'(item.now_ms);
    st_next              = st;
    last_step_time_next  = last_step_time;
    last_check_time_next = last_check_time;
    ramp_end_time_next   = ramp_end_time;
    hold_end_time_next   = hold_end_time;
    step_elapsed         = now_t - last_step_time;
    check_elapsed        = now_t - last_check_time;

    goal  = st.hold_active ? 8'd0 : item.target_speed;
    right = item.direction_right;

    // Latch a new reversal request; hold it until the level reaches zero
    if ((right != st.applied_direction) && !st.reversal_pending) begin
      st_next.wanted_direction = right;
      st_next.reversal_pending = 1'b1;
    end
    if (st_next.reversal_pending) begin
      if (st.level != 8'd0) begin
        goal  = 8'd0;
        right = st.applied_direction;
      end else begin
        st_next.applied_direction = st_next.wanted_direction;
        st_next.reversal_pending  = 1'b0;
      end
    end

    // Ramp one count per step period
    if (goal != st.level) begin
      st_next.ramping     = 1'b1;
      st_next.slow_checks = 4'd0;
      if (step_elapsed >= TIME_BITS'(cfg.ramp_step_ms)) begin
        last_step_time_next = now_t;
        if (st.level < goal) begin
          st_next.level = st.level + 8'd1;
        end else begin
          st_next.level = st.level - 8'd1;
        end
        if (right) begin
          st_next.pwm_two = st_next.level;
          st_next.pwm_one = 8'd0;
        end else begin
          st_next.pwm_one = st_next.level;
          st_next.pwm_two = 8'd0;
        end
      end
    end else begin
      if (st.ramping) begin
        ramp_end_time_next = now_t;
      end
      st_next.ramping = 1'b0;
    end

    diff           = item.encoder_count - st.previous_count;
    delta          = diff[31] ? (~diff + 32'd1) : diff;
    settle_elapsed = now_t - ramp_end_time_next;
    need           = stall_threshold(st_next.level);
    hold_past      = '0;

    // Stall check once per check period
    if (check_elapsed >= TIME_BITS'(cfg.check_period_ms)) begin
      last_check_time_next   = now_t;
      st_next.previous_count = item.encoder_count;
      if (st_next.ramping || (settle_elapsed < TIME_BITS'(cfg.settle_ms))) begin
        st_next.slow_checks = 4'd0;
      end else begin
        if ((delta < 32'(need)) && (delta != 32'd0)) begin
          if (st_next.slow_checks != SLOW_MAX) begin
            st_next.slow_checks = st_next.slow_checks + 4'd1;
          end
        end else begin
          st_next.slow_checks = 4'd0;
        end
        if (st_next.slow_checks > cfg.stall_limit) begin
          st_next.hold_active = 1'b1;
          hold_end_time_next  = now_t + TIME_BITS'(cfg.pin_hold_ms);
          st_next.slow_checks = 4'd0;
        end
        // Release once now is strictly past the hold end in wrapped time
        hold_past = now_t - hold_end_time_next;
        if ((hold_past != '0) && !hold_past[TIME_BITS-1]) begin
          st_next.hold_active = 1'b0;
        end
      end
    end

    result.drive_in1     = st_next.pwm_one;
    result.drive_in2     = st_next.pwm_two;
    result.current_level = st_next.level;
    result.pinned        = st_next.hold_active;
  end

endmodule

`default_nettype wire

[verif/motor_ramp_stall_guard_checker.sv]
// Scoreboard for motor_ramp_stall_guard: watches the input, result and register ports,
// predicts each result word from its own model of the ramp and stall logic, and compares.
// Depends on mrsg_pkg for the word and register types.
`timescale 1ns / 1ps

module motor_ramp_stall_guard_checker
  import mrsg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  in_item_t                  in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  out_item_t                 out_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fails,
  output int                        pending
);

  localparam int PRINT_CAP = 60;

  // register copies
  logic [7:0]  ramp_ms, check_ms;
  logic [15:0] settle_span, hold_span;
  logic [3:0]  slow_limit;

  // motor state
  logic [7:0]  lvl, pwm1, pwm2;
  logic        dir_applied, rev_pending, dir_wanted, in_ramp, held;
  logic [31:0] ramp_end_t, step_t, check_t, hold_end_t, prev_count;
  logic [3:0]  slow_n;

  out_item_t bridge_q[$];

  function automatic logic [31:0] band_need(input logic [7:0] lv);
    int pct;
    pct = int'(lv) * 100 / 255;
    if (pct < 32) return 32'd20;
    if (pct < 45) return 32'd40;
    if (pct < 50) return 32'd45;
    if (pct < 70) return 32'd80;
    if (pct < 90) return 32'd90;
    if (pct < 100) return 32'd140;
    return 32'd0;
  endfunction

  function automatic out_item_t predict_bridge(input in_item_t w);
    logic [7:0]  goal;
    logic        right;
    logic [31:0] now, moved, past;
    out_item_t   r;
    goal  = w.target_speed;
    right = w.direction_right;
    now   = w.now_ms;
    if (held) goal = 8'd0;
    // latch a reversal, then ramp down in the old direction until stopped
    if (right != dir_applied && !rev_pending) begin
      dir_wanted  = right;
      rev_pending = 1'b1;
    end
    if (rev_pending) begin
      if (lvl > 8'd0) begin
        goal  = 8'd0;
        right = dir_applied;
      end else begin
        dir_applied = dir_wanted;
        rev_pending = 1'b0;
      end
    end
    if (goal != lvl) begin
      in_ramp = 1'b1;
      slow_n  = 4'd0;
      if (now - step_t >= {24'd0, ramp_ms}) begin
        step_t = now;
        if (lvl < goal) lvl = lvl + 8'd1;
        else lvl = lvl - 8'd1;
        if (right) begin
          pwm2 = lvl;
          pwm1 = 8'd0;
        end else begin
          pwm1 = lvl;
          pwm2 = 8'd0;
        end
      end
    end else begin
      if (in_ramp) ramp_end_t = now;
      in_ramp = 1'b0;
    end
    if (now - check_t >= {24'd0, check_ms}) begin
      check_t = now;
      moved = w.encoder_count - prev_count;
      if (moved[31]) moved = 32'd0 - moved;
      if (in_ramp || (now - ramp_end_t < {16'd0, settle_span})) begin
        slow_n     = 4'd0;
        prev_count = w.encoder_count;
      end else begin
        if (moved < band_need(lvl) && moved != 32'd0) begin
          if (slow_n != 4'hF) slow_n = slow_n + 4'd1;
        end else begin
          slow_n = 4'd0;
        end
        prev_count = w.encoder_count;
        if (slow_n > slow_limit) begin
          held       = 1'b1;
          hold_end_t = now + {16'd0, hold_span};
          slow_n     = 4'd0;
        end
        past = now - hold_end_t;
        if (past != 32'd0 && !past[31]) held = 1'b0;
      end
    end
    r.drive_in1     = pwm1;
    r.drive_in2     = pwm2;
    r.current_level = lvl;
    r.pinned        = held;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fails < PRINT_CAP) begin
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ramp_ms     = RAMP_STEP_RESET;
      check_ms    = CHECK_PERIOD_RESET;
      settle_span = SETTLE_RESET;
      hold_span   = PIN_HOLD_RESET;
      slow_limit  = STALL_LIMIT_RESET;
      lvl         = 8'd0;
      pwm1        = 8'd0;
      pwm2        = 8'd0;
      dir_applied = 1'b1;
      dir_wanted  = 1'b1;
      rev_pending = 1'b0;
      in_ramp     = 1'b0;
      held        = 1'b0;
      ramp_end_t  = 32'd0;
      step_t      = 32'd0;
      check_t     = 32'd0;
      hold_end_t  = 32'd0;
      prev_count  = 32'd0;
      slow_n      = 4'd0;
      bridge_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_RAMP_STEP:    ramp_ms     = cfg_data[7:0];
          CFG_CHECK_PERIOD: check_ms    = cfg_data[7:0];
          CFG_SETTLE:       settle_span = cfg_data;
          CFG_PIN_HOLD:     hold_span   = cfg_data;
          CFG_STALL_LIMIT:  slow_limit  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) bridge_q.push_back(predict_bridge(in_data));
      if (out_valid && out_ready) begin
        if (bridge_q.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = bridge_q.pop_front();
          if (out_data.drive_in1 != want.drive_in1)
            report_mismatch("drive_in1", out_data.drive_in1, want.drive_in1);
          if (out_data.drive_in2 != want.drive_in2)
            report_mismatch("drive_in2", out_data.drive_in2, want.drive_in2);
          if (out_data.current_level != want.current_level)
            report_mismatch("current_level", out_data.current_level, want.current_level);
          if (out_data.pinned !== want.pinned)
            report_mismatch("pinned", out_data.pinned, want.pinned);
        end
      end
    end
    pending = bridge_q.size();
  end

endmodule

[verif/motor_ramp_stall_guard_tb.sv]
// Testbench top for motor_ramp_stall_guard: clock, reset, stimulus and verdict.
// Depends on mrsg_pkg, the block itself and motor_ramp_stall_guard_checker.
`timescale 1ns / 1ps

module motor_ramp_stall_guard_tb
  import mrsg_pkg::*;
();

  localparam int NUM_PHASES  = 12;
  localparam int FULL_PHASE  = 2;
  localparam int CYCLE_LIMIT = 400000;
  // index past the register map; the block must drop writes to it
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 3'd5;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fails, pending;
  int cycle_n = 0;

  // sender pacing
  int burst_left = 0;

  // receiver pacing
  int  ready_run = 0;

  // running timestamp and encoder position shared by all phases
  logic        [31:0] t_now = 32'd0;
  logic signed [31:0] enc_pos = 32'sd0;

  always #6 clk = ~clk;

  motor_ramp_stall_guard dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  motor_ramp_stall_guard_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fails(fails),
    .pending(pending)
  );

  // Hard stop: a hung handshake or a lost result word ends here.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: alternate ready runs and stalls of random length, with an
  // occasional long run that never stalls.
  always @(negedge clk) begin
    int pick;
    if (ready_run == 0) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        out_ready = 1'b1;
        ready_run = $urandom_range(1, 12);
      end else if (pick <= 8) begin
        out_ready = 1'b0;
        ready_run = $urandom_range(1, 7);
      end else begin
        out_ready = 1'b1;
        ready_run = 80;
      end
    end else begin
      ready_run--;
    end
  end

  // Offer one word, hold it until taken, then either carry on in the burst
  // or drop valid for a random gap. Returns at a falling edge.
  task automatic push_word(input in_item_t w);
    int gap;
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_fields(input logic [7:0] tgt, input logic dir,
                             input logic [31:0] enc, input logic [31:0] stamp);
    in_item_t w;
    w.target_speed    = tgt;
    w.direction_right = dir;
    w.encoder_count   = enc;
    w.now_ms          = stamp;
    push_word(w);
  endtask

  // Hold until every predicted word has come back.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write the whole register set while the block is idle, plus one write to
  // an unmapped index.
  task automatic program_regs(input logic [7:0] rs, input logic [7:0] cp,
                              input logic [15:0] st, input logic [15:0] ph,
                              input logic [3:0] lim);
    wait_drained();
    cfg_write = 1'b1;
    cfg_index = CFG_RAMP_STEP;
    cfg_data  = {8'd0, rs};
    @(negedge clk);
    cfg_index = CFG_CHECK_PERIOD;
    cfg_data  = {8'd0, cp};
    @(negedge clk);
    cfg_index = CFG_SETTLE;
    cfg_data  = st;
    @(negedge clk);
    cfg_index = CFG_PIN_HOLD;
    cfg_data  = ph;
    @(negedge clk);
    cfg_index = CFG_STALL_LIMIT;
    cfg_data  = {12'd0, lim};
    @(negedge clk);
    cfg_index = CFG_UNMAPPED;
    cfg_data  = 16'($urandom);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    logic [7:0]  rs, cp, tgt;
    logic [15:0] st, ph;
    logic [3:0]  lim;
    logic        dir;
    logic [31:0] dt;
    int          tmax, e_max, seg_len, seg_idx, word_budget, sent, step;
    in_item_t    w;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- Directed part ----
    // Reset register values: full speed and extreme encoder and time values,
    // then a reversal request while the level is still above zero.
    send_fields(8'd255, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fields(8'd0,   1'b0, 32'h8000_0000, 32'h0000_0000);

    // Zero ramp and check periods: step and check on every word. A stall
    // limit of zero pins on the first slow check.
    program_regs(8'd0, 8'd0, 16'd0, 16'd4, 4'd0);
    send_fields(8'd3, 1'b0, 32'd0, 32'd100);  // finish ramp-down, reversal waits
    send_fields(8'd3, 1'b0, 32'd0, 32'd101);  // level zero: reversal takes effect
    send_fields(8'd3, 1'b0, 32'd0, 32'd102);
    send_fields(8'd3, 1'b0, 32'd0, 32'd103);
    send_fields(8'd3, 1'b0, 32'd0, 32'd104);  // ramp ends, no movement
    send_fields(8'd3, 1'b0, 32'd5, 32'd105);  // slow check: pin
    send_fields(8'd3, 1'b0, 32'd5, 32'd106);  // pinned: ramp down
    send_fields(8'd3, 1'b0, 32'd5, 32'd107);
    send_fields(8'd3, 1'b0, 32'd5, 32'd108);
    send_fields(8'd3, 1'b0, 32'd5, 32'd109);  // hold end reached, not passed
    send_fields(8'd3, 1'b0, 32'd5, 32'd110);  // strictly past: release
    // Encoder difference of exactly minus two to the 31st.
    send_fields(8'd0, 1'b0, 32'h8000_0005, 32'd111);
    send_fields(8'd0, 1'b0, 32'h0000_0005, 32'd112);
    // Time wrapping through zero, with a fresh ramp across it.
    send_fields(8'd2, 1'b1, 32'h0000_0008, 32'hFFFF_FFFE);
    send_fields(8'd2, 1'b1, 32'h0000_0009, 32'hFFFF_FFFF);
    send_fields(8'd2, 1'b1, 32'h0000_000A, 32'h0000_0001);
    send_fields(8'd2, 1'b1, 32'h0000_000B, 32'h0000_0003);
    send_fields(8'd2, 1'b1, 32'h0000_000C, 32'h0000_0005);
    t_now   = 32'd6;
    enc_pos = 32'sd12;

    // ---- Random phases ----
    // Each phase picks a register set, then plays segments that hold a
    // commanded speed and direction while time and the encoder advance.
    // Phase 0 takes the low extremes, phase 1 the high ones, and the full
    // speed phase walks the level up through every threshold band.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        rs = 8'd0; cp = 8'd0; st = 16'd0; ph = 16'd0; lim = 4'd0;
      end else if (p == 1) begin
        rs = 8'd255; cp = 8'd255; st = 16'hFFFF; ph = 16'hFFFF; lim = 4'hF;
      end else if (p == FULL_PHASE) begin
        rs = 8'd0; cp = 8'($urandom_range(1, 2)); st = 16'($urandom_range(0, 5));
        ph = 16'($urandom_range(5, 30)); lim = 4'($urandom_range(1, 3));
      end else begin
        case ($urandom_range(0, 5))
          0:       rs = 8'd0;
          1:       rs = 8'd255;
          default: rs = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
          0:       cp = 8'd0;
          1:       cp = 8'd255;
          default: cp = 8'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
          0:       st = 16'hFFFF;
          1:       st = 16'($urandom);
          default: st = 16'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 7))
          0:       ph = 16'hFFFF;
          1:       ph = 16'd0;
          default: ph = 16'($urandom_range(1, 200));
        endcase
        lim = 4'($urandom_range(0, 15));
      end
      program_regs(rs, cp, st, ph, lim);

      tmax = ((rs > cp) ? int'(rs) : int'(cp)) / 4 + $urandom_range(1, 3);
      if (p == FULL_PHASE) tmax = 1;
      // sometimes start the phase just short of the time wrap
      if ($urandom_range(0, 3) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 300);

      word_budget = (p == FULL_PHASE) ? 330 : 95;
      sent        = 0;
      seg_idx     = 0;
      dir         = 1'b1;
      while (sent < word_budget) begin
        if (p == FULL_PHASE) begin
          tgt     = (seg_idx >= 5) ? 8'd255 : 8'(seg_idx * 50 + $urandom_range(0, 20));
          seg_len = 55;
          e_max   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30) : $urandom_range(150, 250);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: tgt = 8'($urandom_range(0, 40));
            6, 7:             tgt = 8'($urandom);
            8:                tgt = 8'd255;
            default:          tgt = 8'd0;
          endcase
          if ($urandom_range(0, 3) == 0) dir = ~dir;
          seg_len = $urandom_range(5, 40);
          e_max   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
        end
        for (int k = 0; k < seg_len && sent < word_budget; k++) begin
          // advance time; now and then jump far, rarely by a random word
          case ($urandom_range(0, 59))
            0:       dt = $urandom;
            1, 2:    dt = $urandom_range(0, 70000);
            default: dt = $urandom_range(0, tmax);
          endcase
          t_now = t_now + dt;
          step  = $urandom_range(0, e_max);
          if (dir) enc_pos = enc_pos + step;
          else enc_pos = enc_pos - step;
          w.target_speed    = tgt;
          w.direction_right = dir;
          w.encoder_count   = enc_pos;
          w.now_ms          = t_now;
          // noise: scramble one word's fields
          if ($urandom_range(0, 24) == 0) begin
            w.target_speed    = 8'($urandom);
            w.direction_right = 1'($urandom);
            w.encoder_count   = $urandom;
            if ($urandom_range(0, 1) == 0) w.now_ms = $urandom;
          end
          push_word(w);
          sent++;
        end
        seg_idx++;
      end
    end

    // Drain, let any stray word show up, then give the verdict.
    wait_drained();
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mrsg_pkg.sv
rtl/core/mrsg_step.sv
rtl/core/motor_ramp_stall_guard.sv
verif/motor_ramp_stall_guard_checker.sv
verif/motor_ramp_stall_guard_tb.sv
